FILE: rtl/rhs_pkg.sv
// Shared types and constants for the register hazard scoreboard.
// No dependencies; imported by rhs_eval and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rhs_pkg;

    localparam int NUM_REGS_DEF = 32;
    localparam int REG_W        = 5;
    localparam int ID_W         = 16;

    localparam logic MODE_DECODE    = 1'b0;
    localparam logic MODE_WRITEBACK = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [ID_W-1:0]  instr_id;
        logic             src1_used;
        logic [REG_W-1:0] src1_reg;
        logic             src2_used;
        logic [REG_W-1:0] src2_reg;
        logic             dest_used;
        logic [REG_W-1:0] dest_reg;
    } item_t;

    typedef struct packed {
        logic            stall_res;
        logic            retired;
        logic [ID_W-1:0] dest_last_writer;
    } result_t;

    // Table update produced by one item; also kept as the bypass record.
    typedef struct packed {
        logic             pend_we;
        logic [REG_W-1:0] pend_addr;
        logic [ID_W-1:0]  pend_data;
        logic             ret_we;
        logic [REG_W-1:0] ret_addr;
        logic [ID_W-1:0]  ret_data;
    } wr_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rhs_ram.sv
// One writer-id table: one write port, one registered read port.
// Per-entry valid bits cleared by reset; an unwritten entry reads zero.
`timescale 1ns / 1ps
`default_nettype none

module rhs_ram #(
    parameter int DEPTH = 32,
    parameter int DW    = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/rhs_eval.sv
// Hazard check and retire decision for the item held in the input stage.
// Uses rhs_pkg; table reads arrive registered, with a bypass of the last update.
`timescale 1ns / 1ps
`default_nettype none

module rhs_eval #(
    parameter int NUM_REGS = rhs_pkg::NUM_REGS_DEF
) (
    input  wire rhs_pkg::item_t          item,
    input  wire logic [rhs_pkg::ID_W-1:0] pend_s1,
    input  wire logic [rhs_pkg::ID_W-1:0] pend_s2,
    input  wire logic [rhs_pkg::ID_W-1:0] pend_d,
    input  wire logic [rhs_pkg::ID_W-1:0] ret_d,
    input  wire rhs_pkg::wr_cmd_t        bypass,
    output rhs_pkg::result_t             result,
    output rhs_pkg::wr_cmd_t             wr
);
    import rhs_pkg::*;

    logic            rng_s1;
    logic            rng_s2;
    logic            rng_d;
    logic [ID_W-1:0] p_s1;
    logic [ID_W-1:0] p_s2;
    logic [ID_W-1:0] p_d;
    logic [ID_W-1:0] r_d;
    logic            haz1;
    logic            haz2;
    logic            stall;
    logic            match;

    assign rng_s1 = int'(item.src1_reg) < NUM_REGS;
    assign rng_s2 = int'(item.src2_reg) < NUM_REGS;
    assign rng_d  = int'(item.dest_reg) < NUM_REGS;

    // The update made at the edge this item was loaded is not in the read data.
    always_comb
    begin
        p_s1 = '0;
        p_s2 = '0;
        p_d  = '0;
        r_d  = '0;
        if (rng_s1)
        begin
            p_s1 = (bypass.pend_we && bypass.pend_addr == item.src1_reg)
                   ? bypass.pend_data : pend_s1;
        end
        if (rng_s2)
        begin
            p_s2 = (bypass.pend_we && bypass.pend_addr == item.src2_reg)
                   ? bypass.pend_data : pend_s2;
        end
        if (rng_d)
        begin
            p_d = (bypass.pend_we && bypass.pend_addr == item.dest_reg)
                  ? bypass.pend_data : pend_d;
            r_d = (bypass.ret_we && bypass.ret_addr == item.dest_reg)
                  ? bypass.ret_data : ret_d;
        end
    end

    assign haz1  = item.src1_used && (p_s1 != '0) && (p_s1 < item.instr_id);
    assign haz2  = item.src2_used && (p_s2 != '0) && (p_s2 < item.instr_id);
    assign stall = (item.mode == MODE_DECODE) && (haz1 || haz2);
    assign match = (item.mode == MODE_WRITEBACK) && item.dest_used && rng_d
                   && (p_d != '0) && (p_d == item.instr_id);

    always_comb
    begin
        wr           = '0;
        wr.pend_addr = item.dest_reg;
        wr.ret_addr  = item.dest_reg;
        wr.ret_data  = item.instr_id;
        if (item.mode == MODE_DECODE)
        begin
            wr.pend_we   = !stall && item.dest_used && rng_d;
            wr.pend_data = item.instr_id;
        end
        else
        begin
            wr.pend_we   = match;
            wr.pend_data = '0;
            wr.ret_we    = match;
        end
    end

    assign result.stall_res        = stall;
    assign result.retired          = match;
    assign result.dest_last_writer = match ? item.instr_id : r_d;

endmodule

`default_nettype wire

FILE: rtl/register_hazard_scoreboard.sv
// Top level of the register hazard scoreboard: input stage, tables, result register.
// Depends on rhs_pkg, rhs_ram and rhs_eval.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid, in_stall | in_data  (rhs_pkg::item_t)
//  out     | output    | out_valid, out_stall | out_data (rhs_pkg::result_t)
//
// One item per clock sustained while the output is not stalled; a result moves from its
// transfer through the input stage (table read) and then evaluation into the result register.
// The tables are read while an item is loaded; the update of the item ahead is
// bypassed. Reset clears all valid bits at once, so no clearing pass is needed.
// A stall on the output holds the result register, then the input stage.
`timescale 1ns / 1ps
`default_nettype none

module register_hazard_scoreboard #(
    parameter int NUM_REGS = rhs_pkg::NUM_REGS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire rhs_pkg::item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output rhs_pkg::result_t out_data
);
    import rhs_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    item_t     item_reg;
    logic      item_vld_reg;
    wr_cmd_t   bypass_reg;
    wr_cmd_t   bypass_next;
    result_t   res_reg;
    logic      res_vld_reg;

    logic      load;
    logic      adv;
    wr_cmd_t   wr;
    result_t   result;
    logic [ID_W-1:0] pend_s1;
    logic [ID_W-1:0] pend_s2;
    logic [ID_W-1:0] pend_d;
    logic [ID_W-1:0] ret_d;

    assign adv      = item_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall = item_vld_reg && !adv;
    assign load     = in_valid && !in_stall;

    // Pending-writer table kept as three copies, one per read address.
    rhs_ram #(.DEPTH(NUM_REGS), .DW(ID_W), .AW(AW)) u_pend_s1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (adv && wr.pend_we),
        .wr_addr (AW'(wr.pend_addr)),
        .wr_data (wr.pend_data),
        .rd_en   (load),
        .rd_addr (AW'(in_data.src1_reg)),
        .rd_data (pend_s1)
    );

    rhs_ram #(.DEPTH(NUM_REGS), .DW(ID_W), .AW(AW)) u_pend_s2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (adv && wr.pend_we),
        .wr_addr (AW'(wr.pend_addr)),
        .wr_data (wr.pend_data),
        .rd_en   (load),
        .rd_addr (AW'(in_data.src2_reg)),
        .rd_data (pend_s2)
    );

    rhs_ram #(.DEPTH(NUM_REGS), .DW(ID_W), .AW(AW)) u_pend_d (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (adv && wr.pend_we),
        .wr_addr (AW'(wr.pend_addr)),
        .wr_data (wr.pend_data),
        .rd_en   (load),
        .rd_addr (AW'(in_data.dest_reg)),
        .rd_data (pend_d)
    );

    rhs_ram #(.DEPTH(NUM_REGS), .DW(ID_W), .AW(AW)) u_ret_d (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (adv && wr.ret_we),
        .wr_addr (AW'(wr.ret_addr)),
        .wr_data (wr.ret_data),
        .rd_en   (load),
        .rd_addr (AW'(in_data.dest_reg)),
        .rd_data (ret_d)
    );

    rhs_eval #(.NUM_REGS(NUM_REGS)) u_eval (
        .item    (item_reg),
        .pend_s1 (pend_s1),
        .pend_s2 (pend_s2),
        .pend_d  (pend_d),
        .ret_d   (ret_d),
        .bypass  (bypass_reg),
        .result  (result),
        .wr      (wr)
    );

    // Only an update made at the same edge as the load is missing from the read.
    always_comb
    begin
        bypass_next         = wr;
        bypass_next.pend_we = adv && wr.pend_we;
        bypass_next.ret_we  = adv && wr.ret_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            bypass_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                item_vld_reg <= 1'b0;
            end

            if (adv)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_vld_reg <= 1'b0;
            end

            if (load)
            begin
                bypass_reg <= bypass_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_data;
        end
        if (adv)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

    a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> res_vld_reg)
        else $error("evaluated item did not reach the result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && item_vld_reg && !adv))
        else $error("input stage overwritten while holding an item");

    a_retire_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && wr.ret_we) |->
            (result.retired && result.dest_last_writer == item_reg.instr_id
             && wr.pend_we && wr.pend_data == '0))
        else $error("retire update disagrees with the result");

    a_stall_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && result.stall_res) |-> (!wr.pend_we && !wr.ret_we))
        else $error("stalled decode updated the tables");

endmodule

`default_nettype wire
